// File: src/sha256_pkg.sv
// Package: SHA-256 constants and round functions.
`timescale 1ns / 1ps
package sha256_pkg;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// File: src/sha256_message_hasher.sv
// Top level: streaming SHA-256 hasher with one shared round unit.
`timescale 1ns / 1ps
// Usage
//  s_axis: one item per accepted beat. tdata[7:0] = data_byte, tuser = has_byte,
//  tlast = last (ends the message; its byte, if any, is taken first).
//  m_axis: eight items per message, tdata[31:0] = digest_word,
//  tuser[2:0] = word_index, tlast = last_word (on word 7). Words go out most
//  significant first.
// Timing
//  A byte that does not fill a block leaves the hasher idle and ready. The 64th
//  byte of a block starts a compression: load the schedule from the block
//  memory, 64 rounds at one per cycle, fold into the chain. No new byte is
//  taken until the fold is done. A last item writes padding one byte per
//  cycle from the 0x80 position to byte 63, plus a full pass when the length
//  needs a second block, each pass followed by a compression, then 8 output
//  beats. The round unit sets the sustained rate.
// Reset
//  rst (synchronous, high) loads the initial hash values, clears the length
//  and returns to idle. The block memory is not cleared.
// Stall
//  While m_axis_tready is low the current digest word holds; s_axis_tready
//  stays low until all eight words are taken.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;  // read 16 schedule words from block memory
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_PAD   = 3'd4;  // write padding bytes
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state;
  logic [31:0] chain [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [63:0] total;
  logic [6:0]  cnt;          // round or load counter
  logic [5:0]  pad_pos;
  logic        finishing;    // last item of this message taken
  logic        len_block;    // the block being compressed holds the length
  logic        pad_marked;   // 0x80 already written for this message
  logic [2:0]  out_idx;

  // block memory: 16 words of 32 bits, byte writes, registered read
  logic [31:0] mem [16];
  logic        mem_we;
  logic [5:0]  mem_waddr;
  logic [7:0]  mem_wdata;
  logic [3:0]  mem_raddr;
  logic [31:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      case (mem_waddr[1:0])
        2'd0: mem[mem_waddr[5:2]][31:24] <= mem_wdata;
        2'd1: mem[mem_waddr[5:2]][23:16] <= mem_wdata;
        2'd2: mem[mem_waddr[5:2]][15:8]  <= mem_wdata;
        default: mem[mem_waddr[5:2]][7:0] <= mem_wdata;
      endcase
    end
    mem_rdata <= mem[mem_raddr];
  end

  logic        accept;
  logic [63:0] bits;
  logic [31:0] wt, t1, t2;
  logic [5:0]  rnd;

  assign s_axis_tready = (state == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign bits = {total[60:0], 3'b000};
  assign rnd = cnt[5:0];

  // memory write: message byte at the length position in idle, padding byte at pad_pos
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = total[5:0];
    mem_wdata = s_axis_tdata;
    mem_raddr = cnt[3:0];
    if (state == S_IDLE) begin
      mem_we = accept && s_axis_tuser;
    end else if (state == S_PAD) begin
      mem_we = 1'b1;
      mem_waddr = pad_pos;
      if (pad_pos == total[5:0] && !len_block) begin
        mem_wdata = sha256_pkg::PAD_BYTE;
      end else if (pad_pos >= 6'd56 && len_block) begin
        mem_wdata = bits[6'(63 - 8 * (32'(pad_pos) - 56)) -: 8];
      end else begin
        mem_wdata = 8'h00;
      end
    end
  end

  // message schedule word and round terms t1, t2 for this round
  always_comb begin
    if (rnd < 6'd16) begin
      wt = w[rnd[3:0]];
    end else begin
      wt = sha256_pkg::small_s1(w[4'(rnd - 6'd2)]) + w[4'(rnd - 6'd7)] +
           sha256_pkg::small_s0(w[4'(rnd - 6'd15)]) + w[rnd[3:0]];
    end
    t1 = v[7] + sha256_pkg::big_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) +
         sha256_pkg::ROUND_K[rnd] + wt;
    t2 = sha256_pkg::big_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      cnt <= '0;
      finishing <= 1'b0;
      len_block <= 1'b0;
      pad_marked <= 1'b0;
      out_idx <= '0;
      pad_pos <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::H_INIT[i];
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_axis_tuser) total <= total + 64'd1;
            finishing <= s_axis_tlast;
            len_block <= 1'b0;
            pad_marked <= 1'b0;
            if (s_axis_tlast) pad_pos <= s_axis_tuser ? 6'(total[5:0] + 6'd1) : total[5:0];
            if (s_axis_tuser && total[5:0] == 6'd63) begin
              cnt <= '0;
              state <= S_LOAD;
            end else if (s_axis_tlast) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // first pass writes 0x80 then zeros to the block end; the length
          // joins this block when 0x80 lands below byte 56, else a second
          // pass writes zeros up to 55 and the length bytes
          pad_pos <= pad_pos + 6'd1;
          pad_marked <= 1'b1;
          if (pad_pos == 6'd63) begin
            cnt <= '0;
            state <= S_LOAD;
          end else if (!len_block && pad_pos == total[5:0] && pad_pos < 6'd56) begin
            len_block <= 1'b1;
          end
        end
        S_LOAD: begin
          // read data arrives in the cycle after the address
          if (cnt != 7'd0) w[4'(cnt - 7'd1)] <= mem_rdata;
          if (cnt == 7'd16) begin
            cnt <= '0;
            for (int i = 0; i < 8; i++) v[i] <= chain[i];
            state <= S_ROUND;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_ROUND: begin
          if (rnd >= 6'd16) w[rnd[3:0]] <= wt;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) state <= S_FOLD;
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
          if (!finishing) begin
            state <= S_IDLE;
          end else if (len_block) begin
            out_idx <= '0;
            state <= S_OUT;
          end else begin
            // a block of message bytes still needs 0x80; otherwise only the
            // length is left, in a fresh block
            len_block <= pad_marked;
            pad_pos <= '0;
            state <= S_PAD;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) chain[i] <= sha256_pkg::H_INIT[i];
              total <= '0;
              finishing <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = chain[out_idx];
  assign m_axis_tuser = out_idx;
  assign m_axis_tlast = (out_idx == 3'd7);

endmodule
